// ----- src/aovf_pkg.sv -----
// Package for the alpha outline vertex finder.
// Holds field widths, register indexes, reset values and shared types.
// No dependencies.
package aovf_pkg;

  localparam int ALPHA_W    = 8;
  localparam int VX_W       = 5;
  localparam int VY_W       = 8;
  localparam int FW_W       = 6;
  localparam int FH_W       = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int MAX_WIDTH_DEF  = 32;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd2;

  localparam logic [ALPHA_W-1:0] THRESHOLD_RST = 8'd0;
  localparam logic [FW_W-1:0]    WIDTH_RST     = 6'd32;
  localparam logic [FH_W-1:0]    HEIGHT_RST    = 9'd32;

  typedef struct packed {
    logic [VX_W-1:0] vertex_x;
    logic [VY_W-1:0] vertex_y;
    logic            from_column_pass;
    logic            run_end;
  } vertex_t;

  typedef struct packed {
    logic clear;
    logic mark;
    logic border_we;
    logic opaque;
    logic rd_en;
  } col_ctl_t;

endpackage

// ----- src/aovf_pixel_if.sv -----
// Pixel channel of the alpha outline vertex finder: one alpha word per pixel.
// Depends on aovf_pkg.
interface aovf_pixel_if import aovf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha_value;

  modport source (output valid, output alpha_value, input ready);
  modport sink (input valid, input alpha_value, output ready);
endinterface

// ----- src/aovf_vertex_if.sv -----
// Vertex channel of the alpha outline vertex finder: one vertex per word.
// Depends on aovf_pkg.
interface aovf_vertex_if import aovf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VX_W-1:0] vertex_x;
  logic [VY_W-1:0] vertex_y;
  logic            from_column_pass;
  logic            run_end;

  modport source (output valid, output vertex_x, output vertex_y,
                  output from_column_pass, output run_end, input ready);
  modport sink (input valid, input vertex_x, input vertex_y,
                input from_column_pass, input run_end, output ready);
endinterface

// ----- src/aovf_cfg_regs.sv -----
// Configuration registers and clamped frame limits.
// Depends on aovf_pkg.
module aovf_cfg_regs import aovf_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  output logic [ALPHA_W-1:0]            threshold_o,
  output logic [$clog2(MaxWidth)-1:0]   w_last_o,
  output logic [$clog2(MaxHeight)-1:0]  h_last_o
);

  localparam int XW  = $clog2(MaxWidth);
  localparam int YW  = $clog2(MaxHeight);
  localparam int WCW = (FW_W > $clog2(MaxWidth + 1)) ? FW_W : $clog2(MaxWidth + 1);
  localparam int HCW = (FH_W > $clog2(MaxHeight + 1)) ? FH_W : $clog2(MaxHeight + 1);

  logic [ALPHA_W-1:0] thr_q;
  logic [FW_W-1:0]    fw_q;
  logic [FH_W-1:0]    fh_q;
  logic [WCW-1:0]     fw_e;
  logic [HCW-1:0]     fh_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      fw_q  <= WIDTH_RST;
      fh_q  <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA_THRESHOLD: thr_q <= cfg_data_i[ALPHA_W-1:0];
        CFG_FRAME_WIDTH:     fw_q  <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:    fh_q  <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  assign fw_e = WCW'(fw_q);
  assign fh_e = HCW'(fh_q);

  always_comb begin
    if (fw_e < WCW'(3)) begin
      w_last_o = XW'(2);
    end else if (fw_e > WCW'(MaxWidth)) begin
      w_last_o = XW'(MaxWidth - 1);
    end else begin
      w_last_o = XW'(fw_e - WCW'(1));
    end
    if (fh_e < HCW'(3)) begin
      h_last_o = YW'(2);
    end else if (fh_e > HCW'(MaxHeight)) begin
      h_last_o = YW'(MaxHeight - 1);
    end else begin
      h_last_o = YW'(fh_e - HCW'(1));
    end
  end

  assign threshold_o = thr_q;

endmodule

// ----- src/aovf_col_mem.sv -----
// Per-column memories: first and last opaque interior row, with valid and
// bottom border flags in flip-flops. Depends on aovf_pkg.
module aovf_col_mem import aovf_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  col_ctl_t                      ctl_i,
  input  logic [$clog2(MaxWidth)-1:0]   wr_x_i,
  input  logic [$clog2(MaxHeight)-1:0]  wr_y_i,
  input  logic [$clog2(MaxWidth)-1:0]   rd_x_i,
  output logic [$clog2(MaxHeight)-1:0]  first_o,
  output logic [$clog2(MaxHeight)-1:0]  last_o,
  output logic                          first_v_o,
  output logic                          last_v_o,
  output logic                          border_o
);

  localparam int YW = $clog2(MaxHeight);

  logic [YW-1:0]       first_mem [MaxWidth];
  logic [YW-1:0]       last_mem  [MaxWidth];
  logic [MaxWidth-1:0] fv_q;
  logic [MaxWidth-1:0] lv_q;
  logic [MaxWidth-1:0] border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q     <= '0;
      lv_q     <= '0;
      border_q <= '0;
    end else if (ctl_i.clear) begin
      fv_q     <= '0;
      lv_q     <= '0;
      border_q <= '0;
    end else begin
      if (ctl_i.mark) begin
        if (!fv_q[wr_x_i]) begin
          fv_q[wr_x_i] <= 1'b1;
        end else begin
          lv_q[wr_x_i] <= 1'b1;
        end
      end
      if (ctl_i.border_we) begin
        border_q[wr_x_i] <= ctl_i.opaque;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mark && !fv_q[wr_x_i]) begin
      first_mem[wr_x_i] <= wr_y_i;
    end
    if (ctl_i.mark && fv_q[wr_x_i]) begin
      last_mem[wr_x_i] <= wr_y_i;
    end
    if (ctl_i.rd_en) begin
      first_o   <= first_mem[rd_x_i];
      last_o    <= last_mem[rd_x_i];
      first_v_o <= fv_q[rd_x_i];
      last_v_o  <= lv_q[rd_x_i];
      border_o  <= border_q[rd_x_i];
    end
  end

endmodule

// ----- src/aovf_row_mem.sv -----
// Per-row memory of the start and end columns given by the row pass.
// One write port and two registered read ports. Depends on aovf_pkg.
module aovf_row_mem import aovf_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(MaxHeight)-1:0]  waddr_i,
  input  logic [$clog2(MaxWidth)-1:0]   wstart_i,
  input  logic [$clog2(MaxWidth)-1:0]   wend_i,
  input  logic                          re_i,
  input  logic [$clog2(MaxHeight)-1:0]  raddr_a_i,
  input  logic [$clog2(MaxHeight)-1:0]  raddr_b_i,
  output logic [$clog2(MaxWidth)-1:0]   start_a_o,
  output logic [$clog2(MaxWidth)-1:0]   end_a_o,
  output logic [$clog2(MaxWidth)-1:0]   start_b_o,
  output logic [$clog2(MaxWidth)-1:0]   end_b_o
);

  localparam int XW = $clog2(MaxWidth);

  logic [2*XW-1:0] mem [MaxHeight];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= {wstart_i, wend_i};
    end
    if (re_i) begin
      {start_a_o, end_a_o} <= mem[raddr_a_i];
      {start_b_o, end_b_o} <= mem[raddr_b_i];
    end
  end

endmodule

// ----- src/alpha_outline_vertex_finder_core.sv -----
// Top level of the alpha outline vertex finder: raster counters, row pass,
// column pass sequencer and output register. Depends on aovf_pkg, the two
// channel interfaces, aovf_cfg_regs, aovf_col_mem and aovf_row_mem.
//
//   channel  direction  word
//   pix_i    in         alpha_value of the next pixel in raster order
//   vtx_o    out        vertex_x, vertex_y, from_column_pass, run_end
//   cfg      in         write enable, register index, write data
//
// A pixel is taken every cycle while the output register is free or drained.
// An interior row whose end gives two vertices holds the input in S_ROW2 until
// its second vertex is loaded. After a frame's last pixel the column pass visits
// each interior column, then S_FIN, taking no pixel; each read goes through the
// column memory and then both row memory ports. Output stalls stretch this.
// Reset clears counters and column flags; the row memory needs no clearing.
module alpha_outline_vertex_finder_core import aovf_pkg::*; #(
  parameter int MaxWidth  = MAX_WIDTH_DEF,
  parameter int MaxHeight = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  aovf_pixel_if.sink            pix_i,
  aovf_vertex_if.source         vtx_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);

  localparam logic [2:0] S_PIX  = 3'd0;
  localparam logic [2:0] S_ROW2 = 3'd1;
  localparam logic [2:0] S_CRD  = 3'd2;
  localparam logic [2:0] S_RRD  = 3'd3;
  localparam logic [2:0] S_E1   = 3'd4;
  localparam logic [2:0] S_E2   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [ALPHA_W-1:0] thr;
  logic [XW-1:0]      w_last;
  logic [YW-1:0]      h_last;

  logic [2:0]    st_q, st_d;
  logic [XW-1:0] x_q, y_dummy_unused_guard;
  logic [YW-1:0] y_q;
  logic [XW-1:0] rsf_q, rlo_q;
  logic [XW-1:0] cx_q, cx_d, cx_nxt;
  logic          out_v_q;
  vertex_t       out_q, out_d;
  logic          out_load, out_free;
  vertex_t       hold_q, hold_d;
  logic          pend_v_q, pend_v_d;
  vertex_t       pend_q, pend_d;

  logic          pix_acc, opaque, last_col, last_row, in_row, in_col;
  logic [XW-1:0] row_end;

  col_ctl_t      col_ctl;
  logic [YW-1:0] col_first, col_last;
  logic          col_fv, col_lv, col_border;

  logic          row_we, row_re;
  logic [XW-1:0] ra_s, ra_e, rb_s, rb_e;

  logic          c1_v, c2_v, cand_v;
  vertex_t       cand;

  function automatic vertex_t mk(input logic [XW-1:0] vx, input logic [YW-1:0] vy,
                                 input logic cp, input logic re);
    logic [XW+VX_W-1:0] xe;
    logic [YW+VY_W-1:0] ye;
    vertex_t            v;
    xe = {{VX_W{1'b0}}, vx};
    ye = {{VY_W{1'b0}}, vy};
    v.vertex_x         = xe[VX_W-1:0];
    v.vertex_y         = ye[VY_W-1:0];
    v.from_column_pass = cp;
    v.run_end          = re;
    return v;
  endfunction

  aovf_cfg_regs #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .threshold_o (thr),
    .w_last_o    (w_last),
    .h_last_o    (h_last)
  );

  aovf_col_mem #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_col (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (col_ctl),
    .wr_x_i    (x_q),
    .wr_y_i    (y_q),
    .rd_x_i    (cx_q),
    .first_o   (col_first),
    .last_o    (col_last),
    .first_v_o (col_fv),
    .last_v_o  (col_lv),
    .border_o  (col_border)
  );

  aovf_row_mem #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_row (
    .clk_i     (clk_i),
    .we_i      (row_we),
    .waddr_i   (y_q),
    .wstart_i  (rsf_q),
    .wend_i    (row_end),
    .re_i      (row_re),
    .raddr_a_i (col_first),
    .raddr_b_i (col_last),
    .start_a_o (ra_s),
    .end_a_o   (ra_e),
    .start_b_o (rb_s),
    .end_b_o   (rb_e)
  );

  assign y_dummy_unused_guard = x_q;

  assign out_free    = !out_v_q || vtx_o.ready;
  assign pix_i.ready = (st_q == S_PIX) && out_free;
  assign pix_acc     = pix_i.valid && pix_i.ready;

  assign opaque   = pix_i.alpha_value > thr;
  assign last_col = x_q >= w_last;
  assign last_row = y_q >= h_last;
  assign in_row   = (y_q != '0) && !last_row;
  assign in_col   = (y_dummy_unused_guard != '0) && !last_col;
  assign row_end  = ((rlo_q != '0) && !opaque) ? rlo_q : '0;

  assign c1_v   = col_fv && (ra_s != cx_q) && (ra_e != cx_q);
  assign c2_v   = col_lv && !col_border && (rb_s != cx_q) && (rb_e != cx_q);
  assign cand_v = (st_q == S_E1) ? c1_v : c2_v;
  assign cand   = mk(cx_q, (st_q == S_E1) ? col_first : col_last, 1'b1, 1'b0);
  assign cx_nxt = cx_q + XW'(1);

  always_comb begin
    st_d     = st_q;
    cx_d     = cx_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    hold_d   = hold_q;
    out_load = 1'b0;
    out_d    = pend_q;
    col_ctl  = '0;
    row_we   = 1'b0;
    row_re   = 1'b0;
    case (st_q)
      S_PIX: begin
        if (pix_acc) begin
          col_ctl.clear     = (x_q == '0) && (y_q == '0);
          col_ctl.mark      = in_col && in_row && opaque;
          col_ctl.border_we = in_col && last_row;
          col_ctl.opaque    = opaque;
          if (last_col && in_row) begin
            row_we = 1'b1;
            if (rsf_q != '0) begin
              out_load = 1'b1;
              if (row_end != '0) begin
                out_d  = mk(rsf_q, y_q, 1'b0, 1'b0);
                hold_d = mk(row_end, y_q, 1'b0, 1'b1);
                st_d   = S_ROW2;
              end else begin
                out_d = mk(rsf_q, y_q, 1'b0, 1'b1);
              end
            end
          end
          if (last_col && last_row) begin
            cx_d = XW'(1);
            st_d = S_CRD;
          end
        end
      end
      S_ROW2: begin
        if (out_free) begin
          out_load = 1'b1;
          out_d    = hold_q;
          st_d     = S_PIX;
        end
      end
      S_CRD: begin
        col_ctl.rd_en = 1'b1;
        st_d          = S_RRD;
      end
      S_RRD: begin
        row_re = 1'b1;
        st_d   = S_E1;
      end
      S_E1, S_E2: begin
        if (!(cand_v && pend_v_q && !out_free)) begin
          if (cand_v) begin
            if (pend_v_q) begin
              out_load = 1'b1;
              out_d    = pend_q;
            end
            pend_d   = cand;
            pend_v_d = 1'b1;
          end
          if (st_q == S_E1) begin
            st_d = S_E2;
          end else if (cx_nxt >= w_last) begin
            st_d = S_FIN;
          end else begin
            cx_d = cx_nxt;
            st_d = S_CRD;
          end
        end
      end
      S_FIN: begin
        if (!pend_v_q) begin
          st_d = S_PIX;
        end else if (out_free) begin
          out_load      = 1'b1;
          out_d         = pend_q;
          out_d.run_end = 1'b1;
          pend_v_d      = 1'b0;
          st_d          = S_PIX;
        end
      end
      default: st_d = S_PIX;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_PIX;
      cx_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      rsf_q    <= '0;
      rlo_q    <= '0;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      cx_q     <= cx_d;
      pend_v_q <= pend_v_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (vtx_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (pix_acc) begin
        if (last_col) begin
          rsf_q <= '0;
          rlo_q <= '0;
          x_q   <= '0;
          y_q   <= last_row ? '0 : y_q + YW'(1);
        end else begin
          x_q <= x_q + XW'(1);
          if (in_row && in_col && opaque) begin
            if (rsf_q == '0) begin
              rsf_q <= x_q;
            end else begin
              rlo_q <= x_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    hold_q <= hold_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign vtx_o.valid            = out_v_q;
  assign vtx_o.vertex_x         = out_q.vertex_x;
  assign vtx_o.vertex_y         = out_q.vertex_y;
  assign vtx_o.from_column_pass = out_q.from_column_pass;
  assign vtx_o.run_end          = out_q.run_end;

endmodule
